/* sv/gdo_pkg.sv */
// gdo_pkg: types, constants and calendar helpers for the gregorian date offset block
// no dependencies; imported by gdo_walk and gregorian_date_offset_top
`timescale 1ns / 1ps

package gdo_pkg;

  // field widths fixed by the interface
  localparam int unsigned YEAR_IN_W = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_IN_W  = 5;
  localparam int unsigned STATUS_W  = 2;

  // signed working year, wide enough for any walk from a 14-bit year
  localparam int unsigned YEAR_W    = 16;
  // year mod 400 residue
  localparam int unsigned CYC_W     = 9;
  localparam int unsigned YEAR_CYCLE = 400;
  localparam int unsigned YEAR_MAX  = 9999;

  // residue reduction: compare-subtract of 400 << k for k = MOD_STEPS-1 .. 0
  localparam int unsigned MOD_STEPS = 6;
  localparam int unsigned STEP_W    = 3;

  // month codes
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_IN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // calendar position carried through the month walk
  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [CYC_W-1:0]         cyc;    // year mod 400
    logic [MONTH_W-1:0]       month;
  } cal_t;

  // leap rule from the year mod 400 residue
  function automatic logic is_leap(input logic [CYC_W-1:0] cyc);
    logic century;
    century = (cyc == CYC_W'(100)) || (cyc == CYC_W'(200)) || (cyc == CYC_W'(300));
    return (cyc[1:0] == 2'b00) && !century;
  endfunction

  // length of a month, month assumed 1..12
  function automatic logic [DAY_IN_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_IN_W-1:0] len;
    case (month)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/gdo_walk.sv */
// gdo_walk: one month step of the date walk, shared by every iteration
// depends on gdo_pkg
`timescale 1ns / 1ps

module gdo_walk
  import gdo_pkg::*;
#(
  parameter int unsigned DAY_W = 14
) (
  input  logic                    op_i,
  input  logic signed [DAY_W-1:0] day_i,
  input  cal_t                    cal_i,
  output logic signed [DAY_W-1:0] day_o,
  output cal_t                    cal_o,
  output logic                    done_o
);

  logic [DAY_IN_W-1:0]     len_cur;
  logic [DAY_IN_W-1:0]     len_prev;
  logic signed [DAY_W-1:0] len_cur_s;
  logic signed [DAY_W-1:0] len_prev_s;
  cal_t                    fwd;
  cal_t                    bwd;

  // next month forward, carrying into the year
  always_comb begin
    fwd = cal_i;
    if (cal_i.month == MON_DEC) begin
      fwd.month = MON_JAN;
      fwd.year  = cal_i.year + YEAR_W'(1);
      fwd.cyc   = (cal_i.cyc == CYC_W'(YEAR_CYCLE - 1)) ? '0 : cal_i.cyc + CYC_W'(1);
    end else begin
      fwd.month = cal_i.month + MONTH_W'(1);
    end
  end

  // previous month, borrowing from the year
  always_comb begin
    bwd = cal_i;
    if (cal_i.month == MON_JAN) begin
      bwd.month = MON_DEC;
      bwd.year  = cal_i.year - YEAR_W'(1);
      bwd.cyc   = (cal_i.cyc == '0) ? CYC_W'(YEAR_CYCLE - 1) : cal_i.cyc - CYC_W'(1);
    end else begin
      bwd.month = cal_i.month - MONTH_W'(1);
    end
  end

  // month lengths used by each direction
  assign len_cur    = month_days(cal_i.month, is_leap(cal_i.cyc));
  assign len_prev   = month_days(bwd.month, is_leap(bwd.cyc));
  assign len_cur_s  = $signed(DAY_W'(len_cur));
  assign len_prev_s = $signed(DAY_W'(len_prev));

  // step select
  always_comb begin
    if (!op_i) begin
      done_o = (day_i <= len_cur_s);
      day_o  = day_i - len_cur_s;
      cal_o  = fwd;
    end else begin
      done_o = (day_i >= $signed(DAY_W'(1)));
      day_o  = day_i + len_prev_s;
      cal_o  = bwd;
    end
  end

endmodule

/* sv/gregorian_date_offset_top.sv */
// gregorian_date_offset_top: adds or subtracts a day count to a gregorian date
// depends on gdo_pkg and gdo_walk
`timescale 1ns / 1ps

// channel   direction  ports                                          handshake
// request   in         op_i in_year_i in_month_i in_day_i delta_i     start, busy
// result    out        out_year_o out_month_o out_day_o status_o      valid_o strobe
//
// busy stays high from the accepting edge through the MOD steps, the CHECK state and, for a valid date, the walk;
// the result strobe comes in the cycle after busy's last high cycle, when busy is already low again
// a 4095-day delta walks about 136 months, one month per cycle
// the year mod 400 residue is built by six compare-subtract steps before the date check
// rst_ni clears the sequencer and the strobe; no clearing pass
// results are shown for one cycle only; the receiver cannot stall

module gregorian_date_offset_top
  import gdo_pkg::*;
#(
  parameter int unsigned DELTA_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [YEAR_IN_W-1:0]  in_year_i,
  input  logic [MONTH_W-1:0]    in_month_i,
  input  logic [DAY_IN_W-1:0]   in_day_i,
  input  logic [DELTA_BITS-1:0] delta_i,
  output logic                  valid_o,
  output logic [YEAR_IN_W-1:0]  out_year_o,
  output logic [MONTH_W-1:0]    out_month_o,
  output logic [DAY_IN_W-1:0]   out_day_o,
  output logic [STATUS_W-1:0]   status_o
);

  // signed day count: the wider of delta and day, plus a carry bit and a sign bit
  localparam int unsigned DAY_W = ((DELTA_BITS > DAY_IN_W) ? DELTA_BITS : DAY_IN_W) + 2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MOD   = 4'b0010,
    S_CHECK = 4'b0100,
    S_WALK  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [YEAR_IN_W-1:0]    rem_q, rem_d;
  logic                    op_q;
  logic [YEAR_IN_W-1:0]    raw_year_q;
  logic [MONTH_W-1:0]      raw_month_q;
  logic [DAY_IN_W-1:0]     raw_day_q;
  logic [DELTA_BITS-1:0]   delta_q;
  logic signed [DAY_W-1:0] day_q, day_d;
  cal_t                    cal_q, cal_d;
  logic                    valid_q, valid_d;
  logic [YEAR_IN_W-1:0]    out_year_q, out_year_d;
  logic [MONTH_W-1:0]      out_month_q, out_month_d;
  logic [DAY_IN_W-1:0]     out_day_q, out_day_d;
  logic [STATUS_W-1:0]     status_q, status_d;

  logic                    accept;
  logic [YEAR_IN_W-1:0]    mod_sub;
  logic [DAY_IN_W-1:0]     in_len;
  logic                    in_ok;
  logic signed [DAY_W-1:0] walk_day;
  cal_t                    walk_cal;
  logic                    walk_done;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // shared month step unit
  gdo_walk #(
    .DAY_W (DAY_W)
  ) u_walk (
    .op_i   (op_q),
    .day_i  (day_q),
    .cal_i  (cal_q),
    .day_o  (walk_day),
    .cal_o  (walk_cal),
    .done_o (walk_done)
  );

  // residue reduction term and input date check
  assign mod_sub = YEAR_IN_W'(YEAR_CYCLE) << step_q;
  assign in_len  = month_days(raw_month_q, is_leap(rem_q[CYC_W-1:0]));
  assign in_ok   = (raw_month_q >= MON_JAN) && (raw_month_q <= MON_DEC) &&
                   (raw_day_q != '0) && (raw_day_q <= in_len);

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rem_d       = rem_q;
    day_d       = day_q;
    cal_d       = cal_q;
    valid_d     = 1'b0;
    out_year_d  = out_year_q;
    out_month_d = out_month_q;
    out_day_d   = out_day_q;
    status_d    = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rem_d   = in_year_i;
          step_d  = STEP_W'(MOD_STEPS - 1);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (rem_q >= mod_sub) begin
          rem_d = rem_q - mod_sub;
        end
        if (step_q == '0) begin
          state_d = S_CHECK;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_CHECK: begin
        cal_d.year  = $signed(YEAR_W'(raw_year_q));
        cal_d.cyc   = rem_q[CYC_W-1:0];
        cal_d.month = raw_month_q;
        if (op_q) begin
          day_d = $signed(DAY_W'(raw_day_q)) - $signed(DAY_W'(delta_q));
        end else begin
          day_d = $signed(DAY_W'(raw_day_q)) + $signed(DAY_W'(delta_q));
        end
        if (in_ok) begin
          state_d = S_WALK;
        end else begin
          // bad input date: echo it back
          out_year_d  = raw_year_q;
          out_month_d = raw_month_q;
          out_day_d   = raw_day_q;
          status_d    = ST_BAD_IN;
          valid_d     = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          out_month_d = cal_q.month;
          out_day_d   = day_q[DAY_IN_W-1:0];
          if (cal_q.year < $signed(YEAR_W'(0))) begin
            out_year_d = '0;
            status_d   = ST_RANGE;
          end else if (cal_q.year > $signed(YEAR_W'(YEAR_MAX))) begin
            out_year_d = YEAR_IN_W'(YEAR_MAX);
            status_d   = ST_RANGE;
          end else begin
            out_year_d = cal_q.year[YEAR_IN_W-1:0];
            status_d   = ST_OK;
          end
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          day_d = walk_day;
          cal_d = walk_cal;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    step_q      <= step_d;
    rem_q       <= rem_d;
    day_q       <= day_d;
    cal_q       <= cal_d;
    out_year_q  <= out_year_d;
    out_month_q <= out_month_d;
    out_day_q   <= out_day_d;
    status_q    <= status_d;
    if (accept) begin
      op_q        <= op_i;
      raw_year_q  <= in_year_i;
      raw_month_q <= in_month_i;
      raw_day_q   <= in_day_i;
      delta_q     <= delta_i;
    end
  end

  assign valid_o     = valid_q;
  assign out_year_o  = out_year_q;
  assign out_month_o = out_month_q;
  assign out_day_o   = out_day_q;
  assign status_o    = status_q;

endmodule

/* bench/testbench.sv */
// testbench: self-checking bench for gregorian_date_offset_top, date add and subtract by days
// depends on gdo_pkg and the block rtl; predicts each result and compares strobed outputs
`timescale 1ns / 1ps

module testbench;
  import gdo_pkg::*;

  localparam int unsigned DELTA_W     = 12;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_REQUESTS = 650;

  // request opcodes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef struct {
    logic [YEAR_IN_W-1:0] year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_IN_W-1:0]  day;
    logic [STATUS_W-1:0]  status;
  } date_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  op_i;
  logic [YEAR_IN_W-1:0]  in_year_i;
  logic [MONTH_W-1:0]    in_month_i;
  logic [DAY_IN_W-1:0]   in_day_i;
  logic [DELTA_W-1:0]    delta_i;
  logic                  valid_o;
  logic [YEAR_IN_W-1:0]  out_year_o;
  logic [MONTH_W-1:0]    out_month_o;
  logic [DAY_IN_W-1:0]   out_day_o;
  logic [STATUS_W-1:0]   status_o;

  date_result_t pending_dates[$];
  int unsigned  mismatches;
  int unsigned  requests_sent;
  int unsigned  ok_seen;
  int unsigned  rejected_seen;
  int unsigned  clamped_seen;
  int unsigned  stall_cycles;
  bit           no_pauses;

  gregorian_date_offset_top #(
    .DELTA_BITS(DELTA_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .in_year_i   (in_year_i),
    .in_month_i  (in_month_i),
    .in_day_i    (in_day_i),
    .delta_i     (delta_i),
    .valid_o     (valid_o),
    .out_year_o  (out_year_o),
    .out_month_o (out_month_o),
    .out_day_o   (out_day_o),
    .status_o    (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // gregorian leap rule, remainder taken as non-negative for walked years below zero
  function automatic bit calendar_leap(input int year);
    int r4, r100, r400;
    r4   = ((year % 4) + 4) % 4;
    r100 = ((year % 100) + 100) % 100;
    r400 = ((year % 400) + 400) % 400;
    return (r4 == 0 && r100 != 0) || r400 == 0;
  endfunction

  function automatic int days_of_month(input int year, input int month);
    int len;
    case (month)
      2:            len = calendar_leap(year) ? 29 : 28;
      4, 6, 9, 11:  len = 30;
      default:      len = 31;
    endcase
    return len;
  endfunction

  // expected result of one request: validate, then walk month by month
  function automatic date_result_t shift_date(input logic op,
                                              input logic [YEAR_IN_W-1:0] y,
                                              input logic [MONTH_W-1:0] m,
                                              input logic [DAY_IN_W-1:0] d,
                                              input logic [DELTA_W-1:0] dl);
    date_result_t res;
    int year, month, day;
    year = y;
    month = m;
    day = d;
    res.status = ST_OK;
    if (month < 1 || month > 12 || day < 1 || day > days_of_month(year, month)) begin
      res.status = ST_BAD_IN;
    end else if (op == OP_ADD) begin
      day += dl;
      while (day > days_of_month(year, month)) begin
        day -= days_of_month(year, month);
        month++;
        if (month > 12) begin
          month = 1;
          year++;
        end
      end
    end else begin
      day -= dl;
      while (day < 1) begin
        month--;
        if (month < 1) begin
          month = 12;
          year--;
        end
        day += days_of_month(year, month);
      end
    end
    if (res.status == ST_OK) begin
      if (year < 0) begin
        year = 0;
        res.status = ST_RANGE;
      end else if (year > YEAR_MAX) begin
        year = YEAR_MAX;
        res.status = ST_RANGE;
      end
    end
    res.year  = YEAR_IN_W'(year);
    res.month = MONTH_W'(month);
    res.day   = DAY_IN_W'(day);
    return res;
  endfunction

  // sender gap between requests, skipped during the no-pause stretch
  task automatic pause_sender();
    if (!no_pauses && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  // drive one request, wait for it to be taken, queue its prediction
  task automatic issue_date_request(input logic op,
                                    input logic [YEAR_IN_W-1:0] y,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [DAY_IN_W-1:0] d,
                                    input logic [DELTA_W-1:0] dl);
    start      <= 1'b1;
    op_i       <= op;
    in_year_i  <= y;
    in_month_i <= m;
    in_day_i   <= d;
    delta_i    <= dl;
    do @(posedge clk_i); while (busy);
    pending_dates.push_back(shift_date(op, y, m, d, dl));
    requests_sent++;
    pause_sender();
  endtask

  // zero delta leaves the date alone, except an oversized year that clamps
  task automatic test_zero_delta();
    issue_date_request(OP_ADD, 14'd2024, MON_FEB, 5'd29, 12'd0);
    issue_date_request(OP_SUB, 14'd16383, MON_DEC, 5'd31, 12'd0);
  endtask

  // year carry and borrow across both ends of the range
  task automatic test_year_bounds();
    issue_date_request(OP_ADD, 14'd9999, MON_DEC, 5'd31, 12'd1);
    issue_date_request(OP_SUB, 14'd0, MON_JAN, 5'd1, 12'd1);
    issue_date_request(OP_ADD, 14'd9999, MON_DEC, 5'd31, 12'd4095);
    issue_date_request(OP_SUB, 14'd0, MON_JAN, 5'd1, 12'd4095);
    issue_date_request(OP_ADD, 14'd0, MON_JAN, 5'd1, 12'd4095);
    issue_date_request(OP_SUB, 14'd16383, MON_JAN, 5'd1, 12'd4095);
  endtask

  // rejected dates echo the input fields unchanged; the last case is a valid month end
  task automatic test_date_check();
    issue_date_request(OP_ADD, 14'd2023, 4'd0, 5'd10, 12'd5);
    issue_date_request(OP_SUB, 14'd2023, 4'd13, 5'd1, 12'd5);
    issue_date_request(OP_ADD, 14'd16383, 4'd15, 5'd31, 12'd4095);
    issue_date_request(OP_SUB, 14'd1999, MON_JUN, 5'd0, 12'd1);
    issue_date_request(OP_ADD, 14'd1999, MON_APR, 5'd31, 12'd1);
    issue_date_request(OP_ADD, 14'd1999, MON_JAN, 5'd31, 12'd1);
  endtask

  // century and four-century leap cases
  task automatic test_leap_rule();
    issue_date_request(OP_ADD, 14'd1900, MON_FEB, 5'd29, 12'd1);
    issue_date_request(OP_SUB, 14'd2000, MON_FEB, 5'd29, 12'd365);
    issue_date_request(OP_ADD, 14'd2024, MON_FEB, 5'd29, 12'd1);
    issue_date_request(OP_ADD, 14'd2023, MON_FEB, 5'd29, 12'd1);
    issue_date_request(OP_ADD, 14'd2100, MON_FEB, 5'd28, 12'd1);
    issue_date_request(OP_ADD, 14'd2000, MON_FEB, 5'd28, 12'd1);
  endtask

  // mostly valid dates with random offsets, the rest raw field noise
  task automatic test_random_dates();
    logic [YEAR_IN_W-1:0] y;
    logic [MONTH_W-1:0]   m;
    logic [DAY_IN_W-1:0]  d;
    logic [DELTA_W-1:0]   dl;
    int                   len;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      no_pauses = (i >= 250 && i < 400);
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 9))
          0:       y = YEAR_IN_W'($urandom_range(0, 3));
          1:       y = YEAR_IN_W'($urandom_range(9985, 9999));
          2:       y = YEAR_IN_W'($urandom_range(10000, 16383));
          3:       y = YEAR_IN_W'($urandom_range(0, 99) * 100);
          default: y = YEAR_IN_W'($urandom_range(0, 9999));
        endcase
        m = MONTH_W'($urandom_range(1, 12));
        len = days_of_month(y, m);
        d = ($urandom_range(0, 3) == 0) ? DAY_IN_W'(len) : DAY_IN_W'($urandom_range(1, len));
        case ($urandom_range(0, 7))
          0:       dl = '0;
          1:       dl = '1;
          2:       dl = DELTA_W'($urandom_range(1, 40));
          default: dl = DELTA_W'($urandom());
        endcase
      end else begin
        y  = YEAR_IN_W'($urandom());
        m  = MONTH_W'($urandom());
        d  = DAY_IN_W'($urandom());
        dl = DELTA_W'($urandom());
      end
      issue_date_request(1'($urandom()), y, m, d, dl);
    end
    no_pauses = 1'b0;
  endtask

  // result checker, one strobed result per expectation in order
  always @(posedge clk_i) begin
    date_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_dates.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
      end else begin
        want = pending_dates.pop_front();
        if (out_year_o !== want.year) begin
          $error("out_year mismatch: expected %0d, actual %0d", want.year, out_year_o);
          mismatches++;
        end
        if (out_month_o !== want.month) begin
          $error("out_month mismatch: expected %0d, actual %0d", want.month, out_month_o);
          mismatches++;
        end
        if (out_day_o !== want.day) begin
          $error("out_day mismatch: expected %0d, actual %0d", want.day, out_day_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
          mismatches++;
        end
        case (want.status)
          ST_OK:     ok_seen++;
          ST_BAD_IN: rejected_seen++;
          default:   clamped_seen++;
        endcase
      end
    end
  end

  // watchdog on cycles with neither a request nor a result taken
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_dates.size());
      $display("tb: failure");
      $finish;
    end
  end

  // test sequence
  initial begin
    mismatches    = 0;
    requests_sent = 0;
    ok_seen       = 0;
    rejected_seen = 0;
    clamped_seen  = 0;
    stall_cycles  = 0;
    no_pauses     = 1'b0;
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    op_i       <= OP_ADD;
    in_year_i  <= '0;
    in_month_i <= '0;
    in_day_i   <= '0;
    delta_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_delta();
    test_year_bounds();
    test_date_check();
    test_leap_rule();
    test_random_dates();
    start <= 1'b0;

    // let outstanding results arrive, then watch for stray strobes
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_dates.size() != 0) begin
      $error("%0d expected results never arrived", pending_dates.size());
      mismatches++;
    end

    $display("run covered %0d date requests: %0d moved in range, %0d rejected inputs,",
             requests_sent, ok_seen, rejected_seen);
    $display("%0d clamped years, %0d field mismatches", clamped_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gdo_pkg.sv
sv/gdo_walk.sv
sv/gregorian_date_offset_top.sv
bench/testbench.sv
